// ===== sv/hshp_pkg.sv =====
// Shared constants, types and helper functions of the height slice histogram peak unit.
package hshp_pkg;

	localparam int MAX_BINS   = 512;
	localparam int BIN_BITS   = $clog2(MAX_BINS);
	localparam int LIM_BITS   = $clog2(MAX_BINS + 1);
	localparam int COUNT_BITS = 21;
	localparam int TOTAL_BITS = 30;
	localparam int POS_BITS   = 11;
	localparam int CFG_BITS   = 11;
	localparam int HLIM_BITS  = 10;
	localparam int CIDX_BITS  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_BITS  = $clog2(FIFO_DEPTH);

	localparam logic [31:0] EPS_BITS = 32'h3400_0000;
	localparam logic [31:0] INF_BITS = 32'h7F80_0000;
	localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [CIDX_BITS-1:0] CFG_CELLS_PER_ROW    = 2'd0;
	localparam logic [CIDX_BITS-1:0] CFG_ROWS_PER_SLICE   = 2'd1;
	localparam logic [CIDX_BITS-1:0] CFG_HEIGHT_LIMIT_BIN = 2'd2;

	localparam logic [CFG_BITS-1:0]  RST_CELLS_PER_ROW    = 11'd800;
	localparam logic [CFG_BITS-1:0]  RST_ROWS_PER_SLICE   = 11'd600;
	localparam logic [HLIM_BITS-1:0] RST_HEIGHT_LIMIT_BIN = 10'd200;

	typedef struct packed {
		logic [CFG_BITS-1:0]  cells_per_row;
		logic [CFG_BITS-1:0]  rows_per_slice;
		logic [HLIM_BITS-1:0] height_limit_bin;
	} cfg_t;

	typedef struct packed {
		logic [BIN_BITS-1:0] bin;
		logic                inc;
		logic                last;
	} entry_t;

	typedef struct packed {
		logic [BIN_BITS-1:0]   max_bin;
		logic [COUNT_BITS-1:0] max_count;
		logic [TOTAL_BITS-1:0] total_count;
		logic [BIN_BITS-1:0]   deck_bin;
		logic [COUNT_BITS-1:0] deck_count;
		logic                  deck_found;
	} result_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_RUN,
		ST_PASS1,
		ST_PASS2,
		ST_DONE
	} back_state_t;

	function automatic logic [LIM_BITS-1:0] eff_limit(input cfg_t cfg);
		logic [LIM_BITS-1:0] lim;
		lim = LIM_BITS'(cfg.height_limit_bin);
		if (lim > LIM_BITS'(MAX_BINS)) begin
			lim = LIM_BITS'(MAX_BINS);
		end
		return lim;
	endfunction

endpackage

// ===== sv/hshp_front.sv =====
// Input stage: classifies each cell and tracks its grid position to find its slice.
module hshp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hshp_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          cell_value,
	input  logic                 last_cell,
	input  logic                 queue_full,
	input  logic                 init_busy,
	output logic                 push,
	output hshp_pkg::entry_t     push_entry
);
	import hshp_pkg::*;

	logic [POS_BITS-1:0] col_q;
	logic [POS_BITS-1:0] row_q;
	logic [LIM_BITS-1:0] slice_q;
	logic [POS_BITS-1:0] cpr;
	logic [POS_BITS-1:0] rps;
	logic [31:0]         mag;
	logic                occupied;
	logic                col_wrap;
	logic                row_wrap;

	assign in_ready = !queue_full && !init_busy;
	assign push     = in_valid && in_ready;

	assign cpr      = (cfg.cells_per_row == '0) ? POS_BITS'(1) : cfg.cells_per_row;
	assign rps      = (cfg.rows_per_slice == '0) ? POS_BITS'(1) : cfg.rows_per_slice;
	assign mag      = cell_value & MAG_MASK;
	assign occupied = (mag > EPS_BITS) && (mag <= INF_BITS);
	assign col_wrap = ({1'b0, col_q} + (POS_BITS+1)'(1)) >= {1'b0, cpr};
	assign row_wrap = ({1'b0, row_q} + (POS_BITS+1)'(1)) >= {1'b0, rps};

	assign push_entry.bin  = slice_q[BIN_BITS-1:0];
	assign push_entry.inc  = occupied && (slice_q < eff_limit(cfg));
	assign push_entry.last = last_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			slice_q <= '0;
		end else if (push) begin
			if (last_cell) begin
				col_q   <= '0;
				row_q   <= '0;
				slice_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
					if (slice_q < LIM_BITS'(MAX_BINS)) begin
						slice_q <= slice_q + LIM_BITS'(1);
					end
				end else begin
					row_q <= row_q + POS_BITS'(1);
				end
			end else begin
				col_q <= col_q + POS_BITS'(1);
			end
		end
	end

endmodule

// ===== sv/hshp_fifo.sv =====
// Short queue of classified cells between the input stage and the histogram stage.
module hshp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hshp_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output hshp_pkg::entry_t head
);
	import hshp_pkg::*;

	entry_t                slot_q [FIFO_DEPTH];
	logic [FPTR_BITS-1:0]  wr_ptr_q;
	logic [FPTR_BITS-1:0]  rd_ptr_q;
	logic [FPTR_BITS:0]    count_q;

	assign full      = (count_q == (FPTR_BITS+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FPTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FPTR_BITS+1)'(1);
			end
		end
	end

endmodule

// ===== sv/hshp_back.sv =====
// Histogram stage: bin memory updates, two scan passes with clearing, and the result register.
module hshp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hshp_pkg::cfg_t    cfg,
	input  logic              q_not_empty,
	input  hshp_pkg::entry_t  q_head,
	output logic              pop,
	output logic              init_busy,
	output logic              out_valid,
	input  logic              out_ready,
	output hshp_pkg::result_t result
);
	import hshp_pkg::*;

	logic [COUNT_BITS-1:0] mem_q [MAX_BINS];
	logic [COUNT_BITS-1:0] rdata_q;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [LIM_BITS-1:0]   idx_q;
	logic [LIM_BITS-1:0]   lim;
	logic [LIM_BITS-1:0]   hw_q;
	logic [LIM_BITS-1:0]   clr_lim;

	logic                  upd_v_s1;
	entry_t                upd_s1;
	logic                  fwd_v_q;
	logic [BIN_BITS-1:0]   fwd_bin_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic                  scan_v_s1;
	logic [BIN_BITS-1:0]   scan_idx_s1;

	logic [COUNT_BITS-1:0] max_q;
	logic [BIN_BITS-1:0]   max_bin_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [BIN_BITS-1:0]   deck_bin_q;
	logic [COUNT_BITS-1:0] deck_cnt_q;
	logic                  found_q;
	logic                  out_valid_q;
	result_t               res_q;

	logic                  mem_we;
	logic [BIN_BITS-1:0]   mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic [BIN_BITS-1:0]   mem_raddr;
	logic                  issue;
	logic                  upd_write;
	logic                  load;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] upd_val;
	logic [TOTAL_BITS:0]   sum;

	assign lim       = eff_limit(cfg);
	assign clr_lim   = (hw_q > lim) ? hw_q : lim;
	assign init_busy = (state_q == ST_INIT);
	assign out_valid = out_valid_q;
	assign result    = res_q;

	assign cur       = (fwd_v_q && fwd_bin_q == upd_s1.bin) ? fwd_data_q : rdata_q;
	assign upd_val   = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);
	assign upd_write = upd_v_s1 && upd_s1.inc;
	assign sum       = {1'b0, total_q} + (TOTAL_BITS+1)'(rdata_q);

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		issue     = 1'b0;
		load      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q[BIN_BITS-1:0];
		mem_wdata = '0;
		mem_raddr = idx_q[BIN_BITS-1:0];
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				if (idx_q == LIM_BITS'(MAX_BINS - 1)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				mem_raddr = q_head.bin;
				mem_we    = upd_write;
				mem_waddr = upd_s1.bin;
				mem_wdata = upd_val;
				if (upd_v_s1 && upd_s1.last) begin
					state_d = ST_PASS1;
				end else begin
					pop = q_not_empty;
				end
			end
			ST_PASS1: begin
				issue = (idx_q < lim);
				if (!issue && !scan_v_s1) begin
					state_d = ST_PASS2;
				end
			end
			ST_PASS2: begin
				issue  = (idx_q < clr_lim);
				mem_we = issue;
				if (!issue && !scan_v_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			idx_q       <= '0;
			hw_q        <= '0;
			upd_v_s1    <= 1'b0;
			fwd_v_q     <= 1'b0;
			scan_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			upd_v_s1  <= pop;
			fwd_v_q   <= (state_q == ST_RUN) && upd_write;
			scan_v_s1 <= issue;
			if (state_q != state_d) begin
				idx_q <= '0;
			end else if (issue || state_q == ST_INIT) begin
				idx_q <= idx_q + LIM_BITS'(1);
			end
			if (upd_write && ({1'b0, upd_s1.bin} >= hw_q)) begin
				hw_q <= {1'b0, upd_s1.bin} + LIM_BITS'(1);
			end else if (state_q == ST_DONE) begin
				hw_q <= '0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			upd_s1 <= q_head;
		end
		fwd_bin_q   <= upd_s1.bin;
		fwd_data_q  <= upd_val;
		scan_idx_s1 <= idx_q[BIN_BITS-1:0];
		if (state_q == ST_RUN) begin
			max_q      <= '0;
			max_bin_q  <= '0;
			total_q    <= '0;
			deck_bin_q <= '0;
			deck_cnt_q <= '0;
			found_q    <= 1'b0;
		end
		if (state_q == ST_PASS1 && scan_v_s1) begin
			if (rdata_q > max_q) begin
				max_q     <= rdata_q;
				max_bin_q <= scan_idx_s1;
			end
			total_q <= sum[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum[TOTAL_BITS-1:0];
		end
		if (state_q == ST_PASS2 && scan_v_s1 && ({1'b0, scan_idx_s1} < lim)) begin
			if ({rdata_q, 1'b0} > {1'b0, max_q}) begin
				deck_bin_q <= scan_idx_s1;
				deck_cnt_q <= rdata_q;
				found_q    <= 1'b1;
			end
		end
		if (load) begin
			res_q.max_bin     <= max_bin_q;
			res_q.max_count   <= max_q;
			res_q.total_count <= total_q;
			res_q.deck_bin    <= deck_bin_q;
			res_q.deck_count  <= deck_cnt_q;
			res_q.deck_found  <= found_q;
		end
	end

endmodule

// ===== sv/height_slice_histogram_peak_unit.sv =====
// Top level of the height slice histogram peak unit with its configuration registers.
// Cells are taken at one per cycle while the four-entry queue has room; each
// occupied cell below the height limit is a read-modify-write of its bin in
// a 512-entry count memory with forwarding of the last write, so back-to-back
// hits on one bin are safe. A cell marked last starts two passes over the bins
// below the height limit (max and total, then half-max search while the bins
// are zeroed), during which the queue keeps filling and then holds input off;
// the zeroing pass also covers any higher bin filled before the limit was
// lowered in mid-grid. After reset all 512 count entries are zeroed before any
// cell is taken; register writes are accepted at any time.
module height_slice_histogram_peak_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [hshp_pkg::CIDX_BITS-1:0]        cfg_index,
	input  logic [hshp_pkg::CFG_BITS-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [31:0]                           cell_value,
	input  logic                                  last_cell,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hshp_pkg::BIN_BITS-1:0]         max_bin,
	output logic [hshp_pkg::COUNT_BITS-1:0]       max_count,
	output logic [hshp_pkg::TOTAL_BITS-1:0]       total_count,
	output logic [hshp_pkg::BIN_BITS-1:0]         deck_bin,
	output logic [hshp_pkg::COUNT_BITS-1:0]       deck_count,
	output logic                                  deck_found
);
	import hshp_pkg::*;

	cfg_t    cfg_q;
	entry_t  push_entry;
	entry_t  q_head;
	result_t result;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_not_empty;
	logic    init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cells_per_row    <= RST_CELLS_PER_ROW;
			cfg_q.rows_per_slice   <= RST_ROWS_PER_SLICE;
			cfg_q.height_limit_bin <= RST_HEIGHT_LIMIT_BIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELLS_PER_ROW:    cfg_q.cells_per_row    <= cfg_data;
				CFG_ROWS_PER_SLICE:   cfg_q.rows_per_slice   <= cfg_data;
				CFG_HEIGHT_LIMIT_BIN: cfg_q.height_limit_bin <= cfg_data[HLIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	hshp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cell_value (cell_value),
		.last_cell  (last_cell),
		.queue_full (q_full),
		.init_busy  (init_busy),
		.push       (push),
		.push_entry (push_entry)
	);

	hshp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	hshp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.init_busy   (init_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (result)
	);

	assign max_bin     = result.max_bin;
	assign max_count   = result.max_count;
	assign total_count = result.total_count;
	assign deck_bin    = result.deck_bin;
	assign deck_count  = result.deck_count;
	assign deck_found  = result.deck_found;

endmodule

// ===== sv/hshp_checker.sv =====
// Port-level checks on the result channel of the height slice histogram peak unit.
module hshp_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [hshp_pkg::BIN_BITS-1:0]         max_bin,
	input logic [hshp_pkg::COUNT_BITS-1:0]       max_count,
	input logic [hshp_pkg::TOTAL_BITS-1:0]       total_count,
	input logic [hshp_pkg::BIN_BITS-1:0]         deck_bin,
	input logic [hshp_pkg::COUNT_BITS-1:0]       deck_count,
	input logic                                  deck_found
);
	import hshp_pkg::*;

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(max_bin) && $stable(max_count)
			&& $stable(total_count) && $stable(deck_bin) && $stable(deck_count)
			&& $stable(deck_found))
		else $error("result changed while stalled");

	a_no_deck_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !deck_found |-> deck_bin == '0 && deck_count == '0)
		else $error("deck fields set without a deck slice");

	a_deck_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && deck_found |-> {deck_count, 1'b0} > {1'b0, max_count}
			&& deck_count <= max_count)
		else $error("deck count outside half-max to max");

	a_total_ge_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> total_count >= TOTAL_BITS'(max_count))
		else $error("total below largest slice count");

endmodule

bind height_slice_histogram_peak_unit hshp_checker u_hshp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.max_bin     (max_bin),
	.max_count   (max_count),
	.total_count (total_count),
	.deck_bin    (deck_bin),
	.deck_count  (deck_count),
	.deck_found  (deck_found)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the height slice histogram peak unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hshp_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_PAUSE = 1100;
	localparam longint TOTAL_SAT = (longint'(1) << TOTAL_BITS) - 1;

	typedef struct {
		logic [31:0] value;
		logic        last;
	} cell_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CIDX_BITS-1:0]  cfg_index = CFG_CELLS_PER_ROW;
	logic [CFG_BITS-1:0]   cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [31:0]           cell_value = '0;
	logic                  last_cell = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [BIN_BITS-1:0]   max_bin;
	logic [COUNT_BITS-1:0] max_count;
	logic [TOTAL_BITS-1:0] total_count;
	logic [BIN_BITS-1:0]   deck_bin;
	logic [COUNT_BITS-1:0] deck_count;
	logic                  deck_found;

	cell_item_t cell_q[$];
	result_t    peak_expect_q[$];

	logic [COUNT_BITS-1:0] slice_hist [MAX_BINS];
	int                    pos_col = 0;
	int                    pos_row = 0;
	int                    pos_slice = 0;
	logic [CFG_BITS-1:0]   mdl_cells_per_row = RST_CELLS_PER_ROW;
	logic [CFG_BITS-1:0]   mdl_rows_per_slice = RST_ROWS_PER_SLICE;
	logic [HLIM_BITS-1:0]  mdl_height_limit = RST_HEIGHT_LIMIT_BIN;

	int fail_count = 0;
	int cycle_count = 0;
	int grid_count = 0;
	int stim_items = 0;

	int          burst_left = 1;
	int          gap_left = 0;
	logic [15:0] stall_pat = '1;
	logic [5:0]  stall_pos = '0;

	height_slice_histogram_peak_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cell_value(cell_value),
		.last_cell(last_cell),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.max_bin(max_bin),
		.max_count(max_count),
		.total_count(total_count),
		.deck_bin(deck_bin),
		.deck_count(deck_count),
		.deck_found(deck_found)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < MAX_BINS; i++) begin
			slice_hist[i] = '0;
		end
	end

	task automatic histogram_accept_cell(input logic [31:0] v, input logic lastc);
		logic [31:0]           mag;
		logic                  occ;
		int                    lim;
		int                    cpr;
		int                    rps;
		logic [COUNT_BITS-1:0] mcnt;
		logic [COUNT_BITS-1:0] dcnt;
		int                    mbin;
		int                    dbin;
		longint                total;
		logic                  found;
		result_t               r;
		mag = v & MAG_MASK;
		occ = (mag > EPS_BITS) && (mag <= INF_BITS);
		lim = (int'(mdl_height_limit) < MAX_BINS) ? int'(mdl_height_limit) : MAX_BINS;
		cpr = (mdl_cells_per_row == 0) ? 1 : int'(mdl_cells_per_row);
		rps = (mdl_rows_per_slice == 0) ? 1 : int'(mdl_rows_per_slice);
		if (occ && pos_slice < lim && pos_slice < MAX_BINS) begin
			if (slice_hist[pos_slice] != COUNT_MAX) begin
				slice_hist[pos_slice] = slice_hist[pos_slice] + 1'b1;
			end
		end
		if (pos_col + 1 >= cpr) begin
			pos_col = 0;
			if (pos_row + 1 >= rps) begin
				pos_row = 0;
				if (pos_slice < MAX_BINS) begin
					pos_slice++;
				end
			end else begin
				pos_row++;
			end
		end else begin
			pos_col++;
		end
		if (lastc) begin
			mcnt = '0;
			dcnt = '0;
			mbin = 0;
			dbin = 0;
			total = 0;
			found = 1'b0;
			for (int i = 0; i < lim; i++) begin
				if (i == 0 || slice_hist[i] > mcnt) begin
					mcnt = slice_hist[i];
					mbin = i;
				end
				total += slice_hist[i];
			end
			if (total > TOTAL_SAT) begin
				total = TOTAL_SAT;
			end
			for (int i = 0; i < lim; i++) begin
				if (2 * longint'(slice_hist[i]) > longint'(mcnt)) begin
					dbin = i;
					dcnt = slice_hist[i];
					found = 1'b1;
				end
			end
			r.max_bin = BIN_BITS'(mbin);
			r.max_count = mcnt;
			r.total_count = TOTAL_BITS'(total);
			r.deck_bin = BIN_BITS'(dbin);
			r.deck_count = dcnt;
			r.deck_found = found;
			peak_expect_q.push_back(r);
			for (int i = 0; i < MAX_BINS; i++) begin
				slice_hist[i] = '0;
			end
			pos_col = 0;
			pos_row = 0;
			pos_slice = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				void'(cell_q.pop_front());
			end
			if (gap_left != 0 || cell_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end
			end else begin
				in_valid <= 1'b1;
				cell_value <= cell_q[0].value;
				last_cell <= cell_q[0].last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_pat <= '1;
			stall_pos <= '0;
		end else begin
			stall_pos <= stall_pos + 1'b1;
			if (stall_pos == 0) begin
				stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
			end
			out_ready <= stall_pat[stall_pos[3:0]];
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				histogram_accept_cell(cell_value, last_cell);
			end
			if (out_valid && out_ready) begin
				got.max_bin = max_bin;
				got.max_count = max_count;
				got.total_count = total_count;
				got.deck_bin = deck_bin;
				got.deck_count = deck_count;
				got.deck_found = deck_found;
				if (peak_expect_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: result with none pending: bin %0d max %0d total %0d",
							$realtime, got.max_bin, got.max_count, got.total_count);
					end
					fail_count++;
				end else begin
					want = peak_expect_q.pop_front();
					if (got.max_bin !== want.max_bin || got.max_count !== want.max_count ||
						got.total_count !== want.total_count || got.deck_bin !== want.deck_bin ||
						got.deck_count !== want.deck_count || got.deck_found !== want.deck_found) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch exp max %0d/%0d total %0d deck %0d/%0d/%0d",
								$realtime, want.max_bin, want.max_count, want.total_count,
								want.deck_bin, want.deck_count, want.deck_found);
							$display("%0t:          got max %0d/%0d total %0d deck %0d/%0d/%0d",
								$realtime, got.max_bin, got.max_count, got.total_count,
								got.deck_bin, got.deck_count, got.deck_found);
						end
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [31:0] rand_cell();
		logic        sgn;
		logic [31:0] v;
		sgn = 1'($urandom);
		case ($urandom_range(0, 9))
			0: v = {sgn, 31'd0};
			1, 2: v = {sgn, 31'(EPS_BITS + 32'($urandom_range(0, 4)) - 32'd2)};
			3: v = {sgn, 8'hFF, ($urandom_range(0, 1) == 0) ? 23'd0 : 23'($urandom)};
			4, 5: v = $urandom;
			default: v = {sgn, 8'($urandom_range(8'h69, 8'hFE)), 23'($urandom)};
		endcase
		return v;
	endfunction

	task automatic push_cell(input logic [31:0] v, input logic lastc);
		cell_item_t it;
		it.value = v;
		it.last = lastc;
		cell_q.push_back(it);
		stim_items++;
		if (lastc) begin
			grid_count++;
		end
	endtask

	task automatic push_grid(input int len);
		for (int i = 0; i < len; i++) begin
			push_cell(rand_cell(), i == len - 1);
		end
	endtask

	task automatic push_random_grids(input int n);
		int cpr;
		int rps;
		int lim;
		int span;
		cpr = (mdl_cells_per_row == 0) ? 1 : int'(mdl_cells_per_row);
		rps = (mdl_rows_per_slice == 0) ? 1 : int'(mdl_rows_per_slice);
		lim = (int'(mdl_height_limit) < 24) ? int'(mdl_height_limit) : 24;
		span = cpr * rps * (lim + 2);
		if (span > 40) begin
			span = 40;
		end
		for (int g = 0; g < n; g++) begin
			push_grid($urandom_range(1, span));
		end
	endtask

	task automatic write_settings(input int cpr, input int rps, input int lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CELLS_PER_ROW;
		cfg_data <= CFG_BITS'(cpr);
		mdl_cells_per_row = CFG_BITS'(cpr);
		@(posedge clk);
		cfg_index <= CFG_ROWS_PER_SLICE;
		cfg_data <= CFG_BITS'(rps);
		mdl_rows_per_slice = CFG_BITS'(rps);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT_LIMIT_BIN;
		cfg_data <= CFG_BITS'(lim);
		mdl_height_limit = HLIM_BITS'(lim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (cell_q.size() != 0 || in_valid || peak_expect_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1024;
			2: return 2047;
			3: return $urandom_range(5, 2047);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	initial begin
		int cpr;
		int rps;
		int lim;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Power-on register values: every cell falls into the lowest slice.
		push_random_grids(2);
		wait_drained();

		// One cell per slice, so each special pattern lands in its own bin.
		write_settings(1, 1, 16);
		push_cell(32'h0000_0000, 1'b0);
		push_cell(32'h8000_0000, 1'b0);
		push_cell(32'h3400_0000, 1'b0);
		push_cell(32'h3400_0001, 1'b0);
		push_cell(32'hB400_0000, 1'b0);
		push_cell(32'hB400_0001, 1'b0);
		push_cell(32'h3F80_0000, 1'b0);
		push_cell(32'h7F7F_FFFF, 1'b0);
		push_cell(32'h7F80_0000, 1'b0);
		push_cell(32'hFF80_0000, 1'b0);
		push_cell(32'h7F80_0001, 1'b0);
		push_cell(32'hFFFF_FFFF, 1'b0);
		push_cell(32'h7FC0_0000, 1'b0);
		push_cell(32'h0000_0001, 1'b0);
		push_cell(32'hC120_0000, 1'b0);
		push_cell(32'h3F80_0000, 1'b0);
		push_cell(32'h3F80_0000, 1'b0);
		push_cell(32'h4000_0000, 1'b1);
		// A grid with no occupied cell leaves no deck slice.
		push_cell(32'h7FC0_0000, 1'b0);
		push_cell(32'h0000_0000, 1'b0);
		push_cell(32'h3400_0000, 1'b1);
		wait_drained();

		// Zero sizes act as one; the limit clamps to the full bin count and the
		// grid runs past the last bin.
		write_settings(0, 0, 1023);
		push_grid(530);
		push_random_grids(2);
		wait_drained();

		write_settings(1024, 1024, 0);
		push_random_grids(3);
		wait_drained();

		write_settings(2047, 2047, 512);
		push_random_grids(2);
		wait_drained();

		write_settings(1, 2047, 3);
		push_random_grids(2);
		wait_drained();

		write_settings(2047, 1, 5);
		push_random_grids(2);
		wait_drained();

		write_settings(3, 2, 1);
		push_random_grids(3);
		wait_drained();

		write_settings(1, 1, 512);
		push_random_grids(3);
		wait_drained();

		while (stim_items < 1100 || grid_count < 40) begin
			cpr = pick_size();
			rps = pick_size();
			case ($urandom_range(0, 9))
				0: lim = 0;
				1: lim = 512;
				2: lim = 1023;
				3: lim = $urandom_range(25, 1023);
				default: lim = $urandom_range(1, 24);
			endcase
			write_settings(cpr, rps, lim);
			push_random_grids($urandom_range(2, 6));
			wait_drained();
		end

		if (peak_expect_q.size() != 0) begin
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hshp_pkg.sv
sv/hshp_front.sv
sv/hshp_fifo.sv
sv/hshp_back.sv
sv/height_slice_histogram_peak_unit.sv
sv/hshp_checker.sv
verif/tb_top.sv
